// ----- sv/ibhs_pkg.sv -----
// Shared types, constants and codes of the IMU bias, heading and shock tracker.
// No dependencies; imported by every module of the block.
package ibhs_pkg;

  localparam int unsigned BIAS_SAMPLES_DEF = 256;
  localparam int unsigned MAX_DT_MS_DEF    = 500;

  localparam int unsigned AW      = 16;  // raw sample width
  localparam int unsigned DTW     = 16;  // interval width, covers MAX_DT_MS range
  localparam int unsigned Q8W     = 25;  // yaw rate, bias and swing, Q8
  localparam int unsigned HEADW   = 48;
  localparam int unsigned SHOCKW  = 17;
  localparam int unsigned BASEW   = 33;  // baseline, accel LSB in Q16
  localparam int unsigned MAGW    = 26;  // axis difference magnitude in Q8
  localparam int unsigned SQW     = 2 * MAGW;
  localparam int unsigned SUMW    = SQW + 2;
  localparam int unsigned ROOTW   = SUMW / 2;
  localparam int unsigned IN_DW   = 96;
  localparam int unsigned OUT_DW  = 120;
  localparam int unsigned PADDRW  = 4;

  localparam logic [SHOCKW-1:0] SHOCK_MAX = '1;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_CAL    = 2'd1,
    CMD_ZERO   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_PRESENT = 2'd0,
    REG_STILL   = 2'd1,
    REG_IMPACT  = 2'd2,
    REG_GAIN    = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DSTART,
    ST_DIV,
    ST_CALFIN,
    ST_YAW,
    ST_MUL,
    ST_ACC,
    ST_JOIN
  } state_e;

  typedef struct packed {
    logic start;
    logic seed;
  } lane_ctl_t;

endpackage

// ----- sv/ibhs_axis_lane.sv -----
// One acceleration axis: exponential baseline update and squared deviation.
// Depends on ibhs_pkg.
module ibhs_axis_lane
  import ibhs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lane_ctl_t              ctl_i,
  input  logic signed [AW-1:0]   accel_i,
  input  logic [15:0]            gain_i,
  output logic [SQW-1:0]         sq_o,
  output logic                   valid_o
);

  localparam int unsigned DIFW = BASEW + 1;
  localparam int unsigned PW   = DIFW + 17;

  logic signed [BASEW-1:0] base_q, base_d;
  logic signed [AW-1:0]    a_q;
  logic signed [PW-1:0]    prod_q;
  logic [SQW-1:0]          sq_q;
  logic [2:0]              v_q;

  logic signed [DIFW-1:0]  target_in, target_a, diff_in, diff_a;
  logic [PW-1:0]           pmag;
  logic [PW-1:0]           pq;
  logic signed [BASEW-1:0] step;
  logic [DIFW-1:0]         dmag;
  logic [MAGW-1:0]         mag;

  always_comb begin
    target_in = DIFW'(accel_i) <<< 16;
    target_a  = DIFW'(a_q) <<< 16;
    diff_in   = target_in - DIFW'(base_q);
    diff_a    = target_a - DIFW'(base_q);
    pmag      = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
    pq        = (pmag + PW'(32768)) >> 16;
    step      = prod_q[PW-1] ? -BASEW'(pq) : BASEW'(pq);
    dmag      = diff_a[DIFW-1] ? DIFW'(-diff_a) : DIFW'(diff_a);
    mag       = MAGW'(dmag >> 8);
    base_d    = base_q;
    if (ctl_i.start && ctl_i.seed) begin
      base_d = BASEW'(target_in);
    end else if (v_q[0]) begin
      base_d = base_q + step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      v_q    <= '0;
    end else begin
      base_q <= base_d;
      v_q    <= {v_q[1:0], ctl_i.start};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      a_q    <= accel_i;
      prod_q <= ctl_i.seed ? '0 : PW'(diff_in * $signed({1'b0, gain_i}));
    end
    if (v_q[1]) begin
      sq_q <= mag * mag;
    end
  end

  assign sq_o    = sq_q;
  assign valid_o = v_q[2];

endmodule

// ----- sv/ibhs_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on ibhs_pkg.
module ibhs_div
  import ibhs_pkg::*;
#(
  parameter int unsigned NW = 33,
  parameter int unsigned DW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o,
  output logic          done_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q, den_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [DW:0]   trial;
  logic          fit;

  assign trial = {rem_q, quo_q[NW-1]};
  assign fit   = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(NW);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= cnt_q == CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= fit ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      quo_q <= {quo_q[NW-2:0], fit};
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

// ----- sv/ibhs_isqrt.sv -----
// Merging stage: sums the lane squares and takes the floor square root,
// one result bit per cycle. Depends on ibhs_pkg.
module ibhs_isqrt
  import ibhs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SQW-1:0]   sq_x_i,
  input  logic [SQW-1:0]   sq_y_i,
  input  logic [SQW-1:0]   sq_z_i,
  output logic [ROOTW-1:0] root_o,
  output logic             done_o
);

  logic [SUMW-1:0] v_q, res_q, bit_q;
  logic            busy_q, done_q;
  logic [SUMW:0]   cand;
  logic            take;

  assign cand = {1'b0, res_q} + {1'b0, bit_q};
  assign take = {1'b0, v_q} >= cand;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= SUMW'(sq_x_i) + SUMW'(sq_y_i) + SUMW'(sq_z_i);
      res_q <= '0;
      bit_q <= SUMW'(1) << (SUMW - 2);
    end else if (busy_q) begin
      if (take) begin
        v_q   <= v_q - SUMW'(cand);
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign root_o = ROOTW'(res_q);
  assign done_o = done_q;

endmodule

// ----- sv/imu_bias_heading_shock_tracker.sv -----
// IMU bias, heading and shock tracker, top level.
// Depends on ibhs_pkg, ibhs_axis_lane, ibhs_div and ibhs_isqrt.
//
// Requests arrive on the s_ channel: tuser carries the command (sample, start
// calibration, zero heading), tdata the raw sample and timestamp. Each request
// gives one status result on the m_ channel, held in an output register.
// Registers are written over the APB port; the user must do so only while the
// block is idle, which the block itself does not enforce. While calibrating,
// a sample request runs the serial mean divider (one bit per cycle over the
// scaled calibration sum) followed by the heading multiply and accumulate.
// The shock path (three axis lanes, then a 27-step square root) runs
// alongside. One request is in flight at a time; a new request is taken while
// the previous result still waits in the output register. If the receiver
// stalls, a finished result waits in the block and no further request is
// taken until the output register is free. Reset clears the tracking state,
// but not the output data register, and sets the register defaults.
module imu_bias_heading_shock_tracker
  import ibhs_pkg::*;
#(
  parameter int unsigned BIAS_SAMPLES = BIAS_SAMPLES_DEF,
  parameter int unsigned MAX_DT_MS    = MAX_DT_MS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid,
  output logic              s_tready,
  // accel_x, accel_y, accel_z, gyro_yaw, time_ms
  input  logic [IN_DW-1:0]  s_tdata,
  // cmd
  input  logic [1:0]        s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // yaw_rate, heading, shock, impact, calibrating, calibrated, bias, zero pad
  output logic [OUT_DW-1:0] m_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PADDRW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned CNTW = $clog2(BIAS_SAMPLES + 1);
  localparam int unsigned CSW  = $clog2(BIAS_SAMPLES) + 17;
  localparam int unsigned NW   = CSW + 8;
  localparam int unsigned PRW  = Q8W + DTW + 1;

  // registers
  logic        present_q;
  logic [15:0] still_q, impact_q, gain_q;

  // tracking state
  state_e                  state_q, state_d;
  logic                    seeded_q;
  logic [CNTW-1:0]         cal_left_q;
  logic signed [CSW-1:0]   cal_sum_q;
  logic [Q8W-1:0]          cal_max_q;
  logic signed [Q8W-1:0]   bias_q, yaw_rate_q;
  logic                    cal_done_q;
  logic signed [HEADW-1:0] heading_q;
  logic [31:0]             last_time_q;
  logic [SHOCKW-1:0]       shock_q;
  logic                    shock_done_q;
  logic                    out_valid_q;
  logic [OUT_DW-1:0]       out_data_q;

  // current request
  logic signed [AW-1:0]    yaw_q;
  logic [31:0]             time_q;
  logic [DTW-1:0]          dt_q;
  logic                    head_en_q;
  logic signed [PRW-1:0]   prod_q;

  logic        accept, cfg_wr;
  cmd_e        cmd;
  logic signed [AW-1:0] ax, ay, az, gyro;
  lane_ctl_t   lane_ctl;
  logic [SQW-1:0] sq_x, sq_y, sq_z;
  logic        vx, vy, vz;
  logic [ROOTW-1:0] root;
  logic        root_done;
  logic        div_start, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [CNTW-1:0] n_cnt;
  logic [CSW-1:0]  sum_mag;
  logic [Q8W-1:0]  mean_mag;
  logic signed [Q8W-1:0] mean, swing_s;
  logic [Q8W-1:0]  swing, max_new;
  logic [31:0]     dt;
  logic [PRW-1:0]  pmag;
  logic signed [HEADW:0] head_sum, delta;
  logic [ROOTW-1:0] sh;
  logic        load;

  assign cmd      = cmd_e'(s_tuser);
  assign ax       = s_tdata[15:0];
  assign ay       = s_tdata[31:16];
  assign az       = s_tdata[47:32];
  assign gyro     = s_tdata[63:48];
  assign s_tready = state_q == ST_IDLE;
  assign accept   = s_tvalid && s_tready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;

  assign lane_ctl.start = accept && cmd == CMD_SAMPLE && present_q;
  assign lane_ctl.seed  = !seeded_q;

  ibhs_axis_lane u_lane_x (.clk_i, .rst_ni, .ctl_i(lane_ctl), .accel_i(ax),
                           .gain_i(gain_q), .sq_o(sq_x), .valid_o(vx));
  ibhs_axis_lane u_lane_y (.clk_i, .rst_ni, .ctl_i(lane_ctl), .accel_i(ay),
                           .gain_i(gain_q), .sq_o(sq_y), .valid_o(vy));
  ibhs_axis_lane u_lane_z (.clk_i, .rst_ni, .ctl_i(lane_ctl), .accel_i(az),
                           .gain_i(gain_q), .sq_o(sq_z), .valid_o(vz));

  ibhs_isqrt u_isqrt (.clk_i, .rst_ni, .start_i(vx && vy && vz), .sq_x_i(sq_x),
                      .sq_y_i(sq_y), .sq_z_i(sq_z), .root_o(root),
                      .done_o(root_done));

  // running mean: samples so far, rounded to nearest on the magnitude
  assign n_cnt     = CNTW'(BIAS_SAMPLES) - cal_left_q + 1'b1;
  assign sum_mag   = cal_sum_q[CSW-1] ? CSW'(-cal_sum_q) : CSW'(cal_sum_q);
  assign div_num   = (NW'(sum_mag) << 8) + NW'(n_cnt >> 1);
  assign div_start = state_q == ST_DSTART;

  ibhs_div #(.NW(NW), .DW(CNTW)) u_div (.clk_i, .rst_ni, .start_i(div_start),
                                        .num_i(div_num), .den_i(n_cnt),
                                        .quo_o(div_quo), .done_o(div_done));

  always_comb begin
    mean_mag = Q8W'(div_quo);
    mean     = cal_sum_q[CSW-1] ? -$signed(mean_mag) : $signed(mean_mag);
    swing_s  = (Q8W'(yaw_q) <<< 8) - mean;
    swing    = swing_s[Q8W-1] ? Q8W'(-swing_s) : Q8W'(swing_s);
    max_new  = swing > cal_max_q ? swing : cal_max_q;
    dt       = time_q - last_time_q;
    pmag     = prod_q[PRW-1] ? PRW'(-prod_q) : PRW'(prod_q);
    delta    = prod_q[PRW-1] ? -(HEADW+1)'((pmag + PRW'(128)) >> 8)
                             : (HEADW+1)'((pmag + PRW'(128)) >> 8);
    head_sum = (HEADW+1)'(heading_q) + delta;
    sh       = (root + ROOTW'(128)) >> 8;
    load     = state_q == ST_JOIN && shock_done_q && (!out_valid_q || m_tready);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_SAMPLE && present_q) begin
            state_d = cal_left_q != '0 ? ST_DSTART : ST_YAW;
          end else begin
            state_d = ST_JOIN;
          end
        end
      end
      ST_DSTART: state_d = ST_DIV;
      ST_DIV:    if (div_done) state_d = ST_CALFIN;
      ST_CALFIN: state_d = ST_YAW;
      ST_YAW:    state_d = ST_MUL;
      ST_MUL:    state_d = ST_ACC;
      ST_ACC:    state_d = ST_JOIN;
      ST_JOIN:   if (load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      present_q    <= 1'b0;
      still_q      <= 16'd66;
      impact_q     <= 16'd4915;
      gain_q       <= 16'd2621;
      seeded_q     <= 1'b0;
      cal_left_q   <= '0;
      cal_sum_q    <= '0;
      cal_max_q    <= '0;
      bias_q       <= '0;
      cal_done_q   <= 1'b0;
      heading_q    <= '0;
      last_time_q  <= '0;
      yaw_rate_q   <= '0;
      shock_q      <= '0;
      shock_done_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        case (reg_e'(paddr[3:2]))
          REG_PRESENT: begin
            present_q <= pwdata[0];
            if (pwdata[0]) seeded_q <= 1'b0;
          end
          REG_STILL:  still_q  <= pwdata[15:0];
          REG_IMPACT: impact_q <= pwdata[15:0];
          REG_GAIN:   gain_q   <= pwdata[15:0];
          default: ;
        endcase
      end
      if (accept) begin
        shock_done_q <= !(cmd == CMD_SAMPLE && present_q);
        case (cmd)
          CMD_SAMPLE: begin
            if (present_q) begin
              seeded_q <= 1'b1;
              if (cal_left_q != '0) cal_sum_q <= cal_sum_q + CSW'(gyro);
            end
          end
          CMD_CAL: begin
            cal_left_q <= CNTW'(BIAS_SAMPLES);
            cal_sum_q  <= '0;
            cal_max_q  <= '0;
            cal_done_q <= 1'b0;
          end
          CMD_ZERO: heading_q <= '0;
          default: ;
        endcase
      end
      if (root_done) begin
        shock_q      <= sh > ROOTW'(SHOCK_MAX) ? SHOCK_MAX : SHOCKW'(sh);
        shock_done_q <= 1'b1;
      end
      if (state_q == ST_CALFIN) begin
        cal_max_q  <= max_new;
        cal_left_q <= cal_left_q - 1'b1;
        if (cal_left_q == CNTW'(1) && max_new < Q8W'({still_q, 8'd0})) begin
          bias_q     <= mean;
          cal_done_q <= 1'b1;
        end
      end
      if (state_q == ST_YAW) begin
        yaw_rate_q  <= (Q8W'(yaw_q) <<< 8) - bias_q;
        last_time_q <= time_q;
      end
      if (state_q == ST_ACC && head_en_q) begin
        if (head_sum > $signed((HEADW+1)'({1'b0, {(HEADW-1){1'b1}}}))) begin
          heading_q <= {1'b0, {(HEADW-1){1'b1}}};
        end else if (head_sum < -$signed((HEADW+1)'({2'b01, {(HEADW-1){1'b0}}}))) begin
          heading_q <= {1'b1, {(HEADW-1){1'b0}}};
        end else begin
          heading_q <= HEADW'(head_sum);
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      yaw_q  <= gyro;
      time_q <= s_tdata[95:64];
    end
    if (state_q == ST_YAW) begin
      head_en_q <= last_time_q != '0 && cal_left_q == '0 && dt != '0 &&
                   dt < 32'(MAX_DT_MS);
      dt_q      <= DTW'(dt);
    end
    if (state_q == ST_MUL) begin
      prod_q <= PRW'(yaw_rate_q * $signed({1'b0, dt_q}));
    end
    if (load) begin
      out_data_q <= {2'b00, bias_q, cal_done_q, cal_left_q != '0,
                     present_q && (SHOCKW'(impact_q) < shock_q), shock_q,
                     heading_q, yaw_rate_q};
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_PRESENT: prdata = {31'd0, present_q};
      REG_STILL:   prdata = {16'd0, still_q};
      REG_IMPACT:  prdata = {16'd0, impact_q};
      REG_GAIN:    prdata = {16'd0, gain_q};
      default:     prdata = '0;
    endcase
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = out_data_q;

  a_cal_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd == CMD_CAL |=> cal_left_q == CNTW'(BIAS_SAMPLES))
    else $error("calibration start did not load the sample count");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> m_tvalid)
    else $error("finished result not presented");

  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cal_done_q) |-> cal_left_q == '0)
    else $error("calibration accepted with samples outstanding");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for imu_bias_heading_shock_tracker.
// Depends on ibhs_pkg and the block's RTL; predicts every status result from
// its own model of calibration, heading integration and shock tracking.
module tb
  import ibhs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAL_N    = 256;
  localparam int unsigned DT_LIMIT = 500;
  localparam longint      HEAD_HI  = 64'sd140737488355327;
  localparam longint      HEAD_LO  = -HEAD_HI - 1;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [24:0] yaw_rate;
    logic [47:0] heading;
    logic [16:0] shock;
    logic        impact;
    logic        calibrating;
    logic        calibrated;
    logic [24:0] bias;
  } status_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_DW-1:0]  s_tdata = '0;
  logic [1:0]        s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_DW-1:0] m_tdata;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PADDRW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  imu_bias_heading_shock_tracker DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register copies
  longint cfg_present, cfg_still, cfg_impact, cfg_gain;
  // tracker state
  longint base_x, base_y, base_z, cal_left, cal_sum, cal_max, bias_q8, head_acc;
  longint yaw_q8, shock_last;
  bit     seeded, cal_ok;
  logic [31:0] prev_ms;

  status_t status_q[$];
  int      n_err = 0;
  int      cycles = 0;
  int      stall_left = 0;
  int      n_got = 0;
  int      n_seen = 0;
  bit      no_stall = 1'b0;
  logic [31:0] clock_ms = 32'd1000;

  function automatic longint rnd_div(longint num, longint den);
    longint m;
    m = (num < 0) ? -num : num;
    m = (m + den / 2) / den;
    return (num < 0) ? -m : m;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned q8_abs(longint d);
    return ((d < 0) ? -d : d) >> 8;
  endfunction

  task automatic reset_model();
    cfg_present = 0; cfg_still = 66; cfg_impact = 4915; cfg_gain = 2621;
    base_x = 0; base_y = 0; base_z = 0; seeded = 0;
    cal_left = 0; cal_sum = 0; cal_max = 0; bias_q8 = 0; cal_ok = 0;
    head_acc = 0; prev_ms = '0; yaw_q8 = 0; shock_last = 0;
  endtask

  task automatic take_sample(longint ax, longint ay, longint az, longint yaw,
                             logic [31:0] now);
    longint n, swing;
    logic [31:0] dt;
    longint unsigned dx, dy, dz, s, sh;
    if (cal_left != 0) begin
      n = CAL_N - cal_left + 1;
      cal_sum += yaw;
      swing = yaw * 256 - rnd_div(cal_sum * 256, n);
      if (swing < 0) swing = -swing;
      if (swing > cal_max) cal_max = swing;
      cal_left--;
      if (cal_left == 0 && cal_max < cfg_still * 256) begin
        bias_q8 = rnd_div(cal_sum * 256, CAL_N);
        cal_ok = 1;
      end
    end
    yaw_q8 = yaw * 256 - bias_q8;
    if (prev_ms != 0 && cal_left == 0) begin
      dt = now - prev_ms;
      if (dt > 0 && dt < DT_LIMIT) begin
        head_acc += rnd_div(yaw_q8 * longint'(dt), 256);
        if (head_acc > HEAD_HI) head_acc = HEAD_HI;
        if (head_acc < HEAD_LO) head_acc = HEAD_LO;
      end
    end
    prev_ms = now;
    if (!seeded) begin
      base_x = ax * 65536; base_y = ay * 65536; base_z = az * 65536;
      seeded = 1;
    end else begin
      base_x += rnd_div(cfg_gain * (ax * 65536 - base_x), 65536);
      base_y += rnd_div(cfg_gain * (ay * 65536 - base_y), 65536);
      base_z += rnd_div(cfg_gain * (az * 65536 - base_z), 65536);
    end
    dx = q8_abs(ax * 65536 - base_x);
    dy = q8_abs(ay * 65536 - base_y);
    dz = q8_abs(az * 65536 - base_z);
    s = int_sqrt(dx * dx + dy * dy + dz * dz);
    sh = (s + 128) >> 8;
    shock_last = (sh > 131071) ? 131071 : longint'(sh);
  endtask

  function automatic status_t snapshot();
    status_t r;
    r.yaw_rate    = yaw_q8[24:0];
    r.heading     = head_acc[47:0];
    r.shock       = shock_last[16:0];
    r.impact      = (cfg_present != 0) && (shock_last > cfg_impact);
    r.calibrating = (cal_left != 0);
    r.calibrated  = cal_ok;
    r.bias        = bias_q8[24:0];
    return r;
  endfunction

  task automatic predict_status(cmd_e c, logic signed [15:0] ax, ay, az, yaw,
                                logic [31:0] t);
    case (c)
      CMD_SAMPLE: if (cfg_present != 0) take_sample(ax, ay, az, yaw, t);
      CMD_CAL: begin
        cal_left = CAL_N; cal_sum = 0; cal_max = 0; cal_ok = 0;
      end
      CMD_ZERO: head_acc = 0;
      default: ;
    endcase
    status_q.push_back(snapshot());
  endtask

  task automatic send_req(cmd_e c, logic signed [15:0] ax, ay, az, yaw,
                          logic [31:0] t, int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tuser  = c;
    s_tdata  = {t, yaw, az, ay, ax};
    s_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_tready);
    predict_status(c, ax, ay, az, yaw, t);
  endtask

  task automatic sample_at(logic signed [15:0] ax, ay, az, yaw, int step_ms);
    clock_ms += step_ms;
    send_req(CMD_SAMPLE, ax, ay, az, yaw, clock_ms, $urandom_range(0, 12));
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e r, logic [31:0] v);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = PADDRW'({r, 2'b00}); pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    case (r)
      REG_PRESENT: begin
        cfg_present = v[0];
        if (v[0]) seeded = 0;
      end
      REG_STILL:  cfg_still  = v[15:0];
      REG_IMPACT: cfg_impact = v[15:0];
      default:    cfg_gain   = v[15:0];
    endcase
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic setup(logic p, logic [15:0] still, impact, gain);
    drain();
    write_reg(REG_STILL, still);
    write_reg(REG_IMPACT, impact);
    write_reg(REG_GAIN, gain);
    write_reg(REG_PRESENT, p);
  endtask

  function automatic logic signed [15:0] jitter(int centre, int span);
    return 16'(centre + $urandom_range(0, 2 * span) - span);
  endfunction

  // extremes, dead commands, absent sensor, interval edges
  task automatic test_directed();
    send_req(CMD_SAMPLE, 16'sh7fff, 16'sh8000, 16'sh0001, 16'sh7fff, 32'd5, 0);
    send_req(CMD_NONE, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, '1, 0);
    send_req(CMD_ZERO, '0, '0, '0, '0, '0, 3);
    setup(1'b1, 16'd66, 16'd4915, 16'd2621);
    send_req(CMD_SAMPLE, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 32'd0, 0);
    send_req(CMD_SAMPLE, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 32'd10, 0);
    send_req(CMD_SAMPLE, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 32'd20, 0);
    send_req(CMD_SAMPLE, 0, 0, 8192, 16'sh7fff, 32'd20, 1);    // zero interval
    send_req(CMD_SAMPLE, 0, 0, 8192, 16'sh8000, 32'd519, 2);   // longest interval
    send_req(CMD_SAMPLE, 0, 0, 8192, 16'sh7fff, 32'd1019, 0);  // too long
    send_req(CMD_SAMPLE, 0, 0, 8192, 100, 32'hffff_fff0, 0);
    send_req(CMD_SAMPLE, 0, 0, 8192, 100, 32'd4, 0);           // wrapped timestamp
    send_req(CMD_ZERO, 0, 0, 0, 0, 32'd0, 0);
    send_req(CMD_SAMPLE, 16'sh4000, 16'shc000, 0, -100, 32'd10, 0);
    send_req(CMD_NONE, 0, 0, 0, 0, 32'd0, 0);
    setup(1'b0, 16'd66, 16'd4915, 16'd2621);
    send_req(CMD_ZERO, 0, 0, 0, 0, 32'd0, 0);
    send_req(CMD_CAL, 0, 0, 0, 0, 32'd0, 0);                   // acts while absent
    send_req(CMD_SAMPLE, 1, 2, 3, 4, 32'd50, 0);
    clock_ms = 32'd100;
  endtask

  // one still calibration accepted, one shaken calibration rejected
  task automatic test_calibration();
    setup(1'b1, 16'd66, 16'd4915, 16'd2621);
    no_stall = 1'b1;
    send_req(CMD_CAL, 0, 0, 0, 0, 32'd0, 0);
    repeat (CAL_N) sample_at(jitter(0, 20), jitter(0, 20), jitter(8192, 20),
                             jitter(-37, 10), 5);
    repeat (10) sample_at(0, 0, 8192, jitter(-37, 30), 4);
    no_stall = 1'b0;
    send_req(CMD_CAL, 0, 0, 0, 0, 32'd0, 2);
    repeat (CAL_N) sample_at(jitter(0, 500), 0, 8192,
                             ($urandom_range(0, 30) == 0) ? jitter(0, 30000) : jitter(12, 10),
                             3);
    repeat (5) sample_at(0, 0, 8192, 50, 7);
  endtask

  task automatic random_phase(int items);
    logic signed [15:0] ax, ay, az, yaw;
    int sel, gyro_c;
    gyro_c = $urandom_range(0, 200) - 100;
    for (int i = 0; i < items; i++) begin
      sel = $urandom_range(0, 199);
      if ($urandom_range(0, 99) == 0) drain();      // hold off until all results are in
      if (sel == 0) send_req(CMD_CAL, 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), $urandom, $urandom_range(0, 12));
      else if (sel < 4) send_req(CMD_ZERO, 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom), $urandom,
                                 $urandom_range(0, 12));
      else if (sel < 6) send_req(CMD_NONE, 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom), $urandom,
                                 $urandom_range(0, 12));
      else if (sel < 20) begin
        // raw noise across the full field ranges and odd timestamps
        if ($urandom_range(0, 1)) clock_ms = $urandom;
        sample_at(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom_range(0, 3) == 0 ? $urandom_range(490, 600) : 0);
      end else begin
        ax = jitter(0, 200); ay = jitter(0, 200); az = jitter(8192, 200);
        if ($urandom_range(0, 15) == 0) begin
          ax = 16'($urandom_range(0, 60000) - 30000);
          az = 16'($urandom_range(0, 60000) - 30000);
        end
        yaw = ($urandom_range(0, 9) == 0) ? jitter(0, 20000) : jitter(gyro_c, 15);
        sample_at(ax, ay, az, yaw, $urandom_range(0, 30));
      end
    end
  endtask

  task automatic test_random();
    setup(1'b1, 16'd66, 16'd4915, 16'd2621);
    send_req(CMD_CAL, 0, 0, 0, 0, 32'd0, 0);
    random_phase(150);
    setup(1'b1, 16'd0, 16'd0, 16'd1);
    random_phase(80);
    setup(1'b1, 16'hffff, 16'hffff, 16'hffff);
    send_req(CMD_CAL, 0, 0, 0, 0, 32'd0, 0);
    no_stall = 1'b1;
    random_phase(150);
    no_stall = 1'b0;
    setup(1'b0, 16'd500, 16'd100, 16'd40000);
    random_phase(40);
    setup(1'b1, 16'd500, 16'd200, 16'd30000);
    send_req(CMD_CAL, 0, 0, 0, 0, 32'd0, 0);
    random_phase(130);
  endtask

  initial begin
    reset_model();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_calibration();
    test_random();
    drain();
    if (n_err == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // result side: random stalls per result, some stretches with none
  always @(negedge clk_i) begin
    if (n_got != n_seen) begin
      n_seen = n_got;
      stall_left = no_stall ? 0 : $urandom_range(0, 12);
    end
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_tready <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    status_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_ni && m_tvalid && m_tready) begin
      n_got <= n_got + 1;
      if (status_q.size() == 0) begin
        $error("unexpected result %h", m_tdata);
        n_err++;
      end else begin
        e = status_q.pop_front();
        if (m_tdata[24:0] !== e.yaw_rate) begin
          $error("yaw_rate exp %h got %h", e.yaw_rate, m_tdata[24:0]); n_err++;
        end
        if (m_tdata[72:25] !== e.heading) begin
          $error("heading exp %h got %h", e.heading, m_tdata[72:25]); n_err++;
        end
        if (m_tdata[89:73] !== e.shock) begin
          $error("shock exp %h got %h", e.shock, m_tdata[89:73]); n_err++;
        end
        if (m_tdata[90] !== e.impact) begin
          $error("impact exp %b got %b", e.impact, m_tdata[90]); n_err++;
        end
        if (m_tdata[91] !== e.calibrating) begin
          $error("calibrating exp %b got %b", e.calibrating, m_tdata[91]); n_err++;
        end
        if (m_tdata[92] !== e.calibrated) begin
          $error("calibrated exp %b got %b", e.calibrated, m_tdata[92]); n_err++;
        end
        if (m_tdata[117:93] !== e.bias) begin
          $error("bias exp %h got %h", e.bias, m_tdata[117:93]); n_err++;
        end
      end
    end
  end

endmodule
